// ===== rtl/rmog_pkg.sv =====
// ----------------------------------------------------------------------------
// rmog_pkg: shared types and constants of the motor output guard
// Item layouts, function and register codes, state encoding and reset values.
// ----------------------------------------------------------------------------
package rmog_pkg;

  localparam int NUM_MOTORS_DEFAULT = 8;
  localparam int STORE_DEPTH        = 8;
  localparam int STORE_AW           = $clog2(STORE_DEPTH);
  localparam int MAX_OUT            = 8;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_UPDATE = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic [7:0] CFG_ENABLE_CMD  = 8'd0;
  localparam logic [7:0] CFG_TIMEOUT_CMD = 8'd1;
  localparam logic [7:0] CFG_ID_CMD      = 8'd2;
  localparam logic [7:0] CFG_ID_VALUE    = 8'd3;
  localparam logic [7:0] CFG_DISABLE_VAL = 8'd4;
  localparam logic [7:0] CFG_LONG_PRESS  = 8'd5;

  localparam logic [7:0]  RST_ENABLE_CMD  = 8'd240;
  localparam logic [7:0]  RST_TIMEOUT_CMD = 8'd241;
  localparam logic [7:0]  RST_ID_CMD      = 8'd255;
  localparam logic [7:0]  RST_ID_VALUE    = 8'd102;
  localparam logic [15:0] RST_DISABLE_VAL = 16'd0;
  localparam logic [15:0] RST_LONG_PRESS  = 16'd10;
  localparam logic [7:0]  RST_WD_LIMIT    = 8'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  reg_addr;
    logic [15:0] write_value;
    logic        button_pressed;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        motor_valid;
    logic [2:0]  motor_channel;
    logic [15:0] motor_value;
    logic        last;
    logic        led_on;
    logic        outputs_enabled;
    logic        no_input;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic output_locked;
    logic input_lost;
    logic user_lock;
    logic command_lock;
    logic button_held_lock;
    logic led_level;
  } flags_t;

  // Everything a housekeeping tick reads and rewrites.
  typedef struct packed {
    flags_t      flags;
    logic [15:0] press_count;
    logic [15:0] blink_count;
    logic [7:0]  watchdog_count;
  } hk_state_t;

endpackage

// ===== rtl/rmog_stream_if.sv =====
// ----------------------------------------------------------------------------
// rmog_stream_if: valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface rmog_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rmog_housekeeping.sv =====
// ----------------------------------------------------------------------------
// rmog_housekeeping: tick update of button, LED and watchdog state
// Works out the state that one housekeeping tick leaves behind.
// ----------------------------------------------------------------------------
module rmog_housekeeping (
  input  rmog_pkg::hk_state_t cur,
  input  logic [7:0]          wd_limit,
  input  logic [15:0]         long_press_ticks,
  input  logic                pressed,
  output rmog_pkg::hk_state_t nxt
);

  logic [15:0] pc;
  logic [7:0]  wd;

  always_comb begin
    nxt = cur;
    pc  = cur.press_count;
    if (pressed) begin
      if (!cur.flags.button_held_lock && pc != 16'hFFFF) begin
        pc = pc + 16'd1;
      end
      // A hold past the long-press threshold unlocks.
      if (pc > long_press_ticks) begin
        nxt.flags.button_held_lock = 1'b1;
        nxt.flags.user_lock        = 1'b0;
        if (!cur.flags.command_lock) begin
          nxt.flags.output_locked = 1'b0;
        end
        pc = 16'd0;
      end
    end else begin
      nxt.flags.button_held_lock = 1'b0;
      if (pc != 16'd0) begin
        // A short press locks; a release exactly at the threshold does nothing.
        if (pc < long_press_ticks) begin
          nxt.flags.output_locked = 1'b1;
          nxt.flags.user_lock     = 1'b1;
        end
        pc = 16'd0;
      end
    end
    nxt.press_count = pc;

    if (nxt.flags.user_lock) begin
      nxt.flags.led_level = 1'b0;
    end else if (cur.flags.command_lock) begin
      nxt.flags.led_level = 1'b1;
    end else if (cur.flags.input_lost) begin
      nxt.flags.led_level = |cur.blink_count[1:0];
    end else begin
      nxt.flags.led_level = cur.blink_count[0];
    end
    nxt.blink_count = cur.blink_count + 16'd1;

    wd = cur.watchdog_count + 8'd1;
    nxt.watchdog_count = wd;
    if (wd_limit != 8'd0 && wd > wd_limit && !nxt.flags.output_locked) begin
      nxt.watchdog_count      = 8'd0;
      nxt.flags.input_lost    = 1'b1;
      nxt.flags.output_locked = 1'b1;
    end else if (!cur.flags.command_lock && !nxt.flags.user_lock &&
                 nxt.flags.output_locked && !cur.flags.input_lost) begin
      nxt.flags.output_locked = 1'b0;
    end
  end

endmodule

// ===== rtl/register_mapped_motor_output_guard_unit.sv =====
// ----------------------------------------------------------------------------
// register_mapped_motor_output_guard_unit: bus-mapped motor output guard
// Register writes and reads, housekeeping ticks and motor update streaming.
// ----------------------------------------------------------------------------
// A request word is taken when the block is idle and its result register is
// free or being emptied. Writes, ticks and locked motor updates produce their
// one result word in the cycle after acceptance. A read first goes through the
// registered read of the low bytes, which sit in a synchronous memory, and then
// waits for the result register to be free. An unlocked motor update streams
// min(NUM_MOTORS, 8) words out of the motor value memory, one per cycle at full
// output rate; each is read into the registered memory output before it enters
// the result register, and no request is taken until the last one is in. Both
// memories come out of reset as all zero at once through per-entry valid bits;
// there is no clearing pass. Configuration writes are always taken.
module register_mapped_motor_output_guard_unit #(
  parameter int NUM_MOTORS = rmog_pkg::NUM_MOTORS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  rmog_stream_if.sink   req,
  rmog_stream_if.source rsp,
  rmog_stream_if.sink   cfg
);

  localparam int STREAM_LEN = (NUM_MOTORS < rmog_pkg::MAX_OUT) ?
                              NUM_MOTORS : rmog_pkg::MAX_OUT;
  localparam logic [2:0] LAST_IDX = 3'(STREAM_LEN - 1);
  localparam int AW = rmog_pkg::STORE_AW;

  // Configuration registers.
  logic [7:0]  enable_cmd_code, timeout_cmd_code, id_cmd_code, id_value;
  logic [15:0] disable_value, long_press_ticks;

  // Scalar state.
  rmog_pkg::state_t    state, state_next;
  rmog_pkg::hk_state_t hk, hk_next, hk_tick;
  logic [7:0]          wd_limit, wd_limit_next;
  logic [2:0]          idx, idx_next;

  // Memories with per-entry valid bits.
  logic [7:0]            lb_mem  [rmog_pkg::STORE_DEPTH];
  logic [15:0]           mot_mem [rmog_pkg::STORE_DEPTH];
  logic [rmog_pkg::STORE_DEPTH-1:0] lb_vld, mot_vld;
  logic [7:0]  lb_q;
  logic [15:0] mot_q;
  logic        lb_q_ok, mot_q_ok;
  logic        lb_we, mot_we, lb_re, mot_re;
  logic [AW-1:0] wr_idx, lb_rd_idx, mot_rd_idx;

  // Read source held while the memory read completes.
  logic       rd_use_mem, rd_use_mem_next;
  logic [7:0] rd_alt, rd_alt_next;

  // Result register.
  logic                rsp_valid;
  rmog_pkg::out_item_t rsp_data, rsp_data_next;
  logic                rsp_load, rsp_free;

  rmog_pkg::in_item_t item;
  logic               accept;
  logic               motor_hit, chan_ok, read_hit;
  logic [6:0]         chan;

  assign item     = req.data;
  assign rsp_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == rmog_pkg::ST_IDLE) && rsp_free;
  assign accept   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign chan      = item.reg_addr[7:1];
  assign motor_hit = {1'b0, item.reg_addr} < 9'(2 * NUM_MOTORS);
  assign chan_ok   = chan < 7'(rmog_pkg::STORE_DEPTH);
  assign read_hit  = ({1'b0, item.reg_addr} < 9'(NUM_MOTORS)) &&
                     ({1'b0, item.reg_addr} < 9'(rmog_pkg::STORE_DEPTH));
  assign wr_idx    = chan[AW-1:0];
  assign lb_rd_idx = item.reg_addr[AW-1:0];

  rmog_housekeeping u_hk (
    .cur              (hk),
    .wd_limit         (wd_limit),
    .long_press_ticks (long_press_ticks),
    .pressed          (item.button_pressed),
    .nxt              (hk_tick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_cmd_code  <= rmog_pkg::RST_ENABLE_CMD;
      timeout_cmd_code <= rmog_pkg::RST_TIMEOUT_CMD;
      id_cmd_code      <= rmog_pkg::RST_ID_CMD;
      id_value         <= rmog_pkg::RST_ID_VALUE;
      disable_value    <= rmog_pkg::RST_DISABLE_VAL;
      long_press_ticks <= rmog_pkg::RST_LONG_PRESS;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        rmog_pkg::CFG_ENABLE_CMD:  enable_cmd_code  <= cfg.data.value[7:0];
        rmog_pkg::CFG_TIMEOUT_CMD: timeout_cmd_code <= cfg.data.value[7:0];
        rmog_pkg::CFG_ID_CMD:      id_cmd_code      <= cfg.data.value[7:0];
        rmog_pkg::CFG_ID_VALUE:    id_value         <= cfg.data.value[7:0];
        rmog_pkg::CFG_DISABLE_VAL: disable_value    <= cfg.data.value;
        rmog_pkg::CFG_LONG_PRESS:  long_press_ticks <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // Memory write ports, registered read ports and valid bits.
  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_mem[wr_idx] <= item.write_value[7:0];
    end
    if (mot_we) begin
      mot_mem[wr_idx] <= item.write_value;
    end
    if (lb_re) begin
      lb_q    <= lb_mem[lb_rd_idx];
      lb_q_ok <= lb_vld[lb_rd_idx];
    end
    if (mot_re) begin
      mot_q    <= mot_mem[mot_rd_idx];
      mot_q_ok <= mot_vld[mot_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lb_vld  <= '0;
      mot_vld <= '0;
    end else begin
      if (lb_we) begin
        lb_vld[wr_idx] <= 1'b1;
      end
      if (mot_we) begin
        mot_vld[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rmog_pkg::ST_IDLE;
      hk        <= '{flags: '{output_locked: 1'b1, input_lost: 1'b1, user_lock: 1'b1,
                              command_lock: 1'b0, button_held_lock: 1'b0,
                              led_level: 1'b0},
                     press_count: 16'd0, blink_count: 16'd0, watchdog_count: 8'd0};
      wd_limit  <= rmog_pkg::RST_WD_LIMIT;
      idx       <= 3'd0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      hk       <= hk_next;
      wd_limit <= wd_limit_next;
      idx      <= idx_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_use_mem <= rd_use_mem_next;
    rd_alt     <= rd_alt_next;
    if (rsp_load) begin
      rsp_data <= rsp_data_next;
    end
  end

  always_comb begin
    state_next      = state;
    hk_next         = hk;
    wd_limit_next   = wd_limit;
    idx_next        = idx;
    rd_use_mem_next = rd_use_mem;
    rd_alt_next     = rd_alt;
    lb_we           = 1'b0;
    mot_we          = 1'b0;
    lb_re           = 1'b0;
    mot_re          = 1'b0;
    mot_rd_idx      = idx[AW-1:0];
    rsp_load        = 1'b0;
    rsp_data_next   = '0;

    unique case (state)
      rmog_pkg::ST_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          case (item.func)
            rmog_pkg::FUNC_WRITE: begin
              if (motor_hit) begin
                hk_next.watchdog_count = 8'd0;
                if (chan_ok) begin
                  hk_next.flags.input_lost = 1'b0;
                  lb_we  = !item.reg_addr[0];
                  mot_we = item.reg_addr[0];
                end
              end else if (item.reg_addr == enable_cmd_code) begin
                if (item.write_value == disable_value) begin
                  hk_next.flags.command_lock  = 1'b1;
                  hk_next.flags.output_locked = 1'b1;
                end else begin
                  hk_next.flags.command_lock = 1'b0;
                  if (!hk.flags.user_lock) begin
                    hk_next.flags.output_locked = 1'b0;
                  end
                end
              end else if (item.reg_addr == timeout_cmd_code) begin
                wd_limit_next            = item.write_value[7:0];
                hk_next.flags.input_lost = 1'b0;
              end
            end
            rmog_pkg::FUNC_READ: begin
              rsp_load        = 1'b0;
              lb_re           = read_hit;
              rd_use_mem_next = read_hit;
              // Motor channel addresses read as a low byte or zero, never as the identity.
              rd_alt_next     = (({1'b0, item.reg_addr} >= 9'(NUM_MOTORS)) &&
                                 (item.reg_addr == id_cmd_code)) ? id_value : 8'd0;
              state_next      = rmog_pkg::ST_READ;
            end
            rmog_pkg::FUNC_TICK: begin
              hk_next = hk_tick;
            end
            rmog_pkg::FUNC_UPDATE: begin
              if (!hk.flags.output_locked) begin
                rsp_load   = 1'b0;
                mot_re     = 1'b1;
                mot_rd_idx = '0;
                idx_next   = 3'd0;
                state_next = rmog_pkg::ST_STREAM;
              end
            end
            default: ;
          endcase
          rsp_data_next.last            = 1'b1;
          rsp_data_next.led_on          = hk_next.flags.led_level;
          rsp_data_next.outputs_enabled = !hk_next.flags.output_locked;
          rsp_data_next.no_input        = hk_next.flags.input_lost;
        end
      end
      rmog_pkg::ST_READ: begin
        if (rsp_free) begin
          rsp_load = 1'b1;
          if (rd_use_mem) begin
            rsp_data_next.read_data = lb_q_ok ? lb_q : 8'd0;
          end else begin
            rsp_data_next.read_data = rd_alt;
          end
          rsp_data_next.last            = 1'b1;
          rsp_data_next.led_on          = hk.flags.led_level;
          rsp_data_next.outputs_enabled = !hk.flags.output_locked;
          rsp_data_next.no_input        = hk.flags.input_lost;
          state_next = rmog_pkg::ST_IDLE;
        end
      end
      rmog_pkg::ST_STREAM: begin
        // mot_q holds the entry at idx; fetch the next one as it leaves.
        if (rsp_free) begin
          rsp_load = 1'b1;
          rsp_data_next.motor_valid     = 1'b1;
          rsp_data_next.motor_channel   = idx;
          rsp_data_next.motor_value     = mot_q_ok ? mot_q : 16'd0;
          rsp_data_next.last            = (idx == LAST_IDX);
          rsp_data_next.led_on          = hk.flags.led_level;
          rsp_data_next.outputs_enabled = !hk.flags.output_locked;
          rsp_data_next.no_input        = hk.flags.input_lost;
          if (idx == LAST_IDX) begin
            state_next = rmog_pkg::ST_IDLE;
          end else begin
            idx_next   = idx + 3'd1;
            mot_re     = 1'b1;
            mot_rd_idx = idx_next[AW-1:0];
          end
        end
      end
      default: state_next = rmog_pkg::ST_IDLE;
    endcase
  end

  // A motor value only ever leaves while the outputs are unlocked.
  a_stream_unlocked: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.motor_valid |-> !hk.flags.output_locked)
    else $error("motor value streamed while outputs locked");

  // Only stream words may be followed by more words of the same item.
  a_nonlast_is_stream: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.last |-> rsp.data.motor_valid)
    else $error("non-final word outside a motor stream");

  // A taken non-final stream word is followed at once by the next channel.
  a_stream_next: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && !rsp.data.last |=>
      rsp.valid && rsp.data.motor_valid &&
      rsp.data.motor_channel == $past(rsp.data.motor_channel) + 3'd1)
    else $error("motor stream skipped or stalled a channel");

endmodule

// ===== sim/register_mapped_motor_output_guard_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_mapped_motor_output_guard_unit_test: self-checking bench
// Drives register writes, reads, housekeeping ticks and motor updates through
// the request channel and compares every response word, field by field,
// against an in-bench prediction of the guard. The run opens with a short
// table of directed words and then goes through several register settings with
// random traffic, and ends with a press released exactly at the long-press
// count. Both channels idle at random.
// ----------------------------------------------------------------------------
module register_mapped_motor_output_guard_unit_test;

  localparam int MOTORS      = rmog_pkg::NUM_MOTORS_DEFAULT;
  localparam int REPORT_CAP  = 30;
  localparam int STALL_LIMIT = 5000;

  // Directed words. Only the first rows carry a typed response; they all come
  // before the first tick, so the LED is still dark there.
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  addr;
    logic [15:0] value;
    logic        pressed;
    logic        typed;
    logic [7:0]  want_rd;
    logic        want_en;
    logic        want_lost;
  } probe_row_t;

  typedef struct packed {
    logic                typed;
    rmog_pkg::out_item_t want;
  } tag_t;

  logic clk;
  logic rst;

  rmog_stream_if #(.T(rmog_pkg::in_item_t))  req ();
  rmog_stream_if #(.T(rmog_pkg::out_item_t)) rsp ();
  rmog_stream_if #(.T(rmog_pkg::cfg_item_t)) cfg ();

  register_mapped_motor_output_guard_unit #(.NUM_MOTORS(MOTORS)) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  // Predicted guard state and register settings.
  logic [7:0]  low_bytes [rmog_pkg::STORE_DEPTH];
  logic [15:0] motor_vals [rmog_pkg::STORE_DEPTH];
  logic        out_locked, input_gone, user_locked, cmd_locked, held_lock, led_level;
  logic [15:0] press_ticks, blink_ticks;
  logic [7:0]  wd_ticks, wd_limit;
  logic [7:0]  enable_code, timeout_code, ident_code, ident_byte;
  logic [15:0] lock_value, long_ticks;

  rmog_pkg::out_item_t pending_rsp [$];
  tag_t                row_tags [$];
  probe_row_t          directed_rows [0:27];

  int errors = 0;
  int quiet = 0;
  int sender_burst = 0;
  bit rush = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rmog_pkg::out_item_t status_word(
    input logic [7:0] rd, input logic mv, input logic [2:0] ch, input logic [15:0] val,
    input logic lst);
    return '{rd, mv, ch, val, lst, led_level, !out_locked, input_gone};
  endfunction

  task automatic guard_step(input rmog_pkg::in_item_t item, input logic typed,
                            input rmog_pkg::out_item_t want);
    logic [7:0] rd;
    int idx;
    int count;
    rd = '0;
    count = (MOTORS < rmog_pkg::MAX_OUT) ? MOTORS : rmog_pkg::MAX_OUT;
    case (item.func)
      rmog_pkg::FUNC_WRITE: begin
        // Motor registers shadow the enable command, which shadows the timeout.
        if (item.reg_addr < 2 * MOTORS) begin
          wd_ticks = '0;
          idx = item.reg_addr >> 1;
          if (idx < rmog_pkg::STORE_DEPTH) begin
            input_gone = 1'b0;
            if (!item.reg_addr[0]) low_bytes[idx] = item.write_value[7:0];
            else motor_vals[idx] = item.write_value;
          end
        end else if (item.reg_addr == enable_code) begin
          if (item.write_value == lock_value) begin
            cmd_locked = 1'b1;
            out_locked = 1'b1;
          end else begin
            cmd_locked = 1'b0;
            if (!user_locked) out_locked = 1'b0;
          end
        end else if (item.reg_addr == timeout_code) begin
          wd_limit = item.write_value[7:0];
          input_gone = 1'b0;
        end
      end
      rmog_pkg::FUNC_READ: begin
        if (item.reg_addr < MOTORS) begin
          rd = (item.reg_addr < rmog_pkg::STORE_DEPTH) ? low_bytes[item.reg_addr] : '0;
        end else if (item.reg_addr == ident_code) begin
          rd = ident_byte;
        end
      end
      rmog_pkg::FUNC_TICK: begin
        if (item.button_pressed) begin
          if (!held_lock && press_ticks != 16'hFFFF) press_ticks++;
          if (press_ticks > long_ticks) begin
            held_lock = 1'b1;
            user_locked = 1'b0;
            if (!cmd_locked) out_locked = 1'b0;
            press_ticks = '0;
          end
        end else begin
          held_lock = 1'b0;
          if (press_ticks != 0) begin
            // A release exactly at the long-press count neither locks nor unlocks.
            if (press_ticks < long_ticks) begin
              out_locked = 1'b1;
              user_locked = 1'b1;
            end
            press_ticks = '0;
          end
        end
        if (user_locked) led_level = 1'b0;
        else if (cmd_locked) led_level = 1'b1;
        else led_level = input_gone ? (blink_ticks[1:0] != 2'd0) : blink_ticks[0];
        blink_ticks++;
        wd_ticks++;
        if (wd_limit != 0 && wd_ticks > wd_limit && !out_locked) begin
          wd_ticks = '0;
          input_gone = 1'b1;
          out_locked = 1'b1;
        end else if (!cmd_locked && !user_locked && out_locked && !input_gone) begin
          out_locked = 1'b0;
        end
      end
      default: ;
    endcase
    if (item.func == rmog_pkg::FUNC_UPDATE && !out_locked) begin
      for (int k = 0; k < count; k++)
        pending_rsp.push_back(status_word('0, 1'b1, 3'(k), motor_vals[k], k == count - 1));
    end else if (typed) begin
      pending_rsp.push_back(want);
    end else begin
      pending_rsp.push_back(status_word(rd, 1'b0, 3'd0, 16'd0, 1'b1));
    end
  endtask

  // Scoreboard, prediction on acceptance and the stall watchdog.
  always @(posedge clk) begin : watch
    tag_t tag;
    rmog_pkg::out_item_t want;
    bit moved;
    moved = 1'b0;
    if (rsp.valid && rsp.ready) begin
      moved = 1'b1;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t ns: response word with none expected, actual %p", $time, rsp.data);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.data !== want) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display({"%0t ns: mismatch (expected/actual) rd %h/%h mv %b/%b ch %0d/%0d ",
                      "val %h/%h last %b/%b led %b/%b en %b/%b noin %b/%b"}, $time,
                     want.read_data, rsp.data.read_data, want.motor_valid,
                     rsp.data.motor_valid, want.motor_channel, rsp.data.motor_channel,
                     want.motor_value, rsp.data.motor_value, want.last, rsp.data.last,
                     want.led_on, rsp.data.led_on, want.outputs_enabled,
                     rsp.data.outputs_enabled, want.no_input, rsp.data.no_input);
        end
      end
    end
    if (req.valid && req.ready) begin
      moved = 1'b1;
      tag = row_tags.pop_front();
      guard_step(req.data, tag.typed, tag.want);
    end
    if (cfg.valid && cfg.ready) begin
      moved = 1'b1;
      case (cfg.data.index)
        rmog_pkg::CFG_ENABLE_CMD:  enable_code = cfg.data.value[7:0];
        rmog_pkg::CFG_TIMEOUT_CMD: timeout_code = cfg.data.value[7:0];
        rmog_pkg::CFG_ID_CMD:      ident_code = cfg.data.value[7:0];
        rmog_pkg::CFG_ID_VALUE:    ident_byte = cfg.data.value[7:0];
        rmog_pkg::CFG_DISABLE_VAL: lock_value = cfg.data.value;
        rmog_pkg::CFG_LONG_PRESS:  long_ticks = cfg.data.value;
        default: ;
      endcase
    end
    quiet = moved ? 0 : quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("register_mapped_motor_output_guard_unit_test: done, errors");
      $finish;
    end
  end

  // Response side: random stalls, open stretches, and one long hold on request.
  initial begin : drain
    int stall;
    int open_run;
    stall = 0;
    open_run = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if (rush || open_run > 0) begin
        if (open_run > 0) open_run--;
        rsp.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 15))
          0: open_run = $urandom_range(20, 60);
          1: stall = $urandom_range(8, 40);
          2, 3, 4: stall = $urandom_range(1, 3);
          default: ;
        endcase
        rsp.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  task automatic push_request(input rmog_pkg::in_item_t item, input logic typed,
                              input rmog_pkg::out_item_t want);
    int gap;
    int r;
    gap = 0;
    if (!rush) begin
      if (sender_burst > 0) begin
        sender_burst--;
      end else begin
        if ($urandom_range(0, 19) == 0) sender_burst = $urandom_range(10, 30);
        r = $urandom_range(0, 99);
        if (r < 55) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_tags.push_back('{typed, want});
    req.valid <= 1'b1;
    req.data <= item;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic settle();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_setting(input logic [7:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= '{index, value};
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic rmog_pkg::in_item_t tick_word(input logic pressed);
    return '{rmog_pkg::FUNC_TICK, 8'($urandom), 16'($urandom), pressed};
  endfunction

  // One random sequence: mostly well-formed presses and traffic, some noise.
  task automatic offer_burst(output int sent);
    rmog_pkg::in_item_t item;
    int n;
    sent = 0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        // Held presses: past the long-press count unlocks, shorter ones lock, one exactly at it does neither.
        if ($urandom_range(0, 1) == 0) n = int'(long_ticks) + $urandom_range(1, 2);
        else n = $urandom_range(1, int'(long_ticks));
        repeat (n) begin
          push_request(tick_word(1'b1), 1'b0, '0);
          sent++;
        end
        push_request(tick_word(1'b0), 1'b0, '0);
        sent++;
      end
      5, 6, 7, 8: begin
        item = '{rmog_pkg::FUNC_WRITE, 8'($urandom_range(0, 2 * MOTORS - 1)),
                 16'($urandom), 1'b0};
        push_request(item, 1'b0, '0);
        sent = 1;
      end
      9, 10, 11, 12: begin
        item = '{rmog_pkg::FUNC_UPDATE, 8'($urandom), 16'($urandom), 1'($urandom)};
        push_request(item, 1'b0, '0);
        sent = 1;
      end
      13, 14: begin
        item = '{rmog_pkg::FUNC_READ, 8'($urandom), 16'($urandom), 1'($urandom)};
        case ($urandom_range(0, 2))
          0: item.reg_addr = 8'($urandom_range(0, MOTORS - 1));
          1: item.reg_addr = ident_code;
          default: ;
        endcase
        push_request(item, 1'b0, '0);
        sent = 1;
      end
      15: begin
        item = '{rmog_pkg::FUNC_WRITE, enable_code, 16'($urandom), 1'b0};
        if ($urandom_range(0, 1) == 0) item.write_value = lock_value;
        push_request(item, 1'b0, '0);
        sent = 1;
      end
      16: begin
        item = '{rmog_pkg::FUNC_WRITE, timeout_code, 16'($urandom), 1'b0};
        case ($urandom_range(0, 4))
          0: item.write_value[7:0] = 8'h00;
          1: item.write_value[7:0] = 8'hFF;
          default: item.write_value[7:0] = 8'($urandom_range(2, 12));
        endcase
        push_request(item, 1'b0, '0);
        sent = 1;
      end
      17: begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          push_request(tick_word(1'b0), 1'b0, '0);
          sent++;
        end
      end
      default: begin
        item = '{2'($urandom), 8'($urandom), 16'($urandom), 1'($urandom)};
        push_request(item, 1'b0, '0);
        sent = 1;
      end
    endcase
  endtask

  initial begin : stimulus
    probe_row_t row;
    rmog_pkg::out_item_t want;
    logic [7:0] en, to, id, idv;
    logic [15:0] dis, lp;
    int sent, n;
    bit paused;

    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;

    for (int i = 0; i < rmog_pkg::STORE_DEPTH; i++) begin
      low_bytes[i] = '0;
      motor_vals[i] = '0;
    end
    out_locked = 1'b1;
    input_gone = 1'b1;
    user_locked = 1'b1;
    cmd_locked = 1'b0;
    held_lock = 1'b0;
    led_level = 1'b0;
    press_ticks = '0;
    blink_ticks = '0;
    wd_ticks = '0;
    wd_limit = rmog_pkg::RST_WD_LIMIT;
    enable_code = rmog_pkg::RST_ENABLE_CMD;
    timeout_code = rmog_pkg::RST_TIMEOUT_CMD;
    ident_code = rmog_pkg::RST_ID_CMD;
    ident_byte = rmog_pkg::RST_ID_VALUE;
    lock_value = rmog_pkg::RST_DISABLE_VAL;
    long_ticks = rmog_pkg::RST_LONG_PRESS;

    directed_rows = '{
      '{rmog_pkg::FUNC_READ,   8'hFF, 16'h0000, 1'b0, 1'b1, 8'd102, 1'b0, 1'b1},
      '{rmog_pkg::FUNC_READ,   8'h00, 16'h0000, 1'b0, 1'b1, 8'h00,  1'b0, 1'b1},
      '{rmog_pkg::FUNC_UPDATE, 8'h00, 16'h0000, 1'b0, 1'b1, 8'h00,  1'b0, 1'b1},
      '{rmog_pkg::FUNC_WRITE,  8'h01, 16'hFFFF, 1'b0, 1'b1, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_WRITE,  8'h0E, 16'hA5C3, 1'b0, 1'b1, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_WRITE,  8'h0F, 16'h0000, 1'b0, 1'b1, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_READ,   8'h07, 16'h0000, 1'b0, 1'b1, 8'hC3,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_WRITE,  8'hFF, 16'h1234, 1'b0, 1'b1, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_READ,   8'h08, 16'h0000, 1'b0, 1'b1, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_WRITE,  8'hF1, 16'hFF00, 1'b0, 1'b1, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_WRITE,  8'hF0, 16'h0000, 1'b0, 1'b1, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_WRITE,  8'hF0, 16'hFFFF, 1'b0, 1'b1, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b0, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_UPDATE, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_TICK,   8'h00, 16'h0000, 1'b0, 1'b0, 8'h00,  1'b0, 1'b0},
      '{rmog_pkg::FUNC_UPDATE, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00,  1'b0, 1'b0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: identity read, locked update, motor stores, a zero timeout,
    // the lock command both ways, then a long press that unlocks the stream
    // and a short one that locks it again.
    for (int i = 0; i < $size(directed_rows); i++) begin
      row = directed_rows[i];
      want = '{row.want_rd, 1'b0, 3'd0, 16'd0, 1'b1, 1'b0, row.want_en, row.want_lost};
      push_request('{row.func, row.addr, row.value, row.pressed}, row.typed, want);
    end
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          en = 8'hF0; to = 8'hF1; id = 8'hFF; idv = 8'h00; dis = 16'h0000; lp = 16'd3;
        end
        1: begin
          // Both command codes fall on motor registers, the identity on a store.
          en = 8'h00; to = 8'h00; id = 8'h00; idv = 8'hFF; dis = 16'hFFFF; lp = 16'd1;
        end
        3: begin
          // Enable and timeout share one address; the enable command wins.
          en = 8'hFF; to = 8'hFF; id = 8'hFF; idv = 8'hA5; dis = 16'h8001; lp = 16'd2;
        end
        default: begin
          en = 8'($urandom_range(16, 255));
          to = ($urandom_range(0, 3) == 0) ? en : 8'($urandom_range(16, 255));
          id = 8'($urandom);
          idv = 8'($urandom);
          dis = 16'($urandom);
          lp = 16'($urandom_range(1, 6));
        end
      endcase
      write_setting(rmog_pkg::CFG_ENABLE_CMD, 16'(en));
      write_setting(rmog_pkg::CFG_TIMEOUT_CMD, 16'(to));
      write_setting(rmog_pkg::CFG_ID_CMD, 16'(id));
      write_setting(rmog_pkg::CFG_ID_VALUE, 16'(idv));
      write_setting(rmog_pkg::CFG_DISABLE_VAL, dis);
      write_setting(rmog_pkg::CFG_LONG_PRESS, lp);

      sent = 0;
      paused = 1'b0;
      while (sent < 55) begin
        if (p == 1 && sent >= 20 && sent < 25) hold_req = 1'b1;
        if (!paused && sent >= 27) begin
          paused = 1'b1;
          settle();
        end
        offer_burst(n);
        sent += n;
      end
      settle();
    end

    // A press released exactly at the long-press count must leave the locks
    // alone; a release first clears any count left over from random traffic.
    write_setting(rmog_pkg::CFG_ENABLE_CMD, 16'h0055);
    write_setting(rmog_pkg::CFG_TIMEOUT_CMD, 16'h00AA);
    write_setting(rmog_pkg::CFG_ID_CMD, 16'h007E);
    write_setting(rmog_pkg::CFG_ID_VALUE, 16'h0081);
    write_setting(rmog_pkg::CFG_DISABLE_VAL, 16'h5555);
    write_setting(rmog_pkg::CFG_LONG_PRESS, 16'd5);
    rush = 1'b1;
    push_request(tick_word(1'b0), 1'b0, '0);
    repeat (5) push_request(tick_word(1'b1), 1'b0, '0);
    push_request(tick_word(1'b0), 1'b0, '0);
    push_request('{rmog_pkg::FUNC_UPDATE, 8'h00, 16'h0000, 1'b0}, 1'b0, '0);
    push_request('{rmog_pkg::FUNC_READ, 8'h7E, 16'h0000, 1'b0}, 1'b0, '0);
    rush = 1'b0;
    settle();

    if (errors == 0) begin
      $display("register_mapped_motor_output_guard_unit_test: done, clean");
    end else begin
      $display("register_mapped_motor_output_guard_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rmog_pkg.sv
rtl/rmog_stream_if.sv
rtl/rmog_housekeeping.sv
rtl/register_mapped_motor_output_guard_unit.sv
sim/register_mapped_motor_output_guard_unit_test.sv
